>>> hdl/bfsra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsra_pkg
// shared constants and types of the best-fit sequence ram allocator
// ----------------------------------------------------------------------------
package bfsra_pkg;

    localparam int ADDR_BITS    = 11;
    localparam int MAX_SEGMENTS = 64;

    localparam int SEG_AW = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);

    localparam logic [11:0] ADDR_MASK = 12'((1 << ADDR_BITS) - 1);

    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_FREE   = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_SPACE  = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED = 3'd2;
    localparam logic [2:0] ST_UNUSED    = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [11:0] start;
        logic [12:0] size;
        logic [5:0]  owner;
    } t_seg;

endpackage

>>> hdl/best_fit_sequence_ram_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_sequence_ram_allocator_core
// segment table in one ram, best-fit gap walk, index map and table shifts
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | sink      | i_in_valid / o_in_ready | i_mode i_length i_seq_index i_offset
//  out     | source    | o_out_valid/i_out_ready | o_status o_given_index o_address
//
//  one word at a time; a new word is taken once the previous result is in the
//  output register. time from accept to result is set by the single table ram
//  port pair: allocate walks the table and shifts entries pos and up, free walks
//  to the owner and shifts the entries above it down, lookup walks to the owner;
//  rejected words skip the walk. the core returns to idle before the next word.
//  after reset the first two table entries are written, input held off
//  the output register holds a result while o_out_valid waits for i_out_ready
// ----------------------------------------------------------------------------
module best_fit_sequence_ram_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [12:0] i_length,
    input  logic [5:0]  i_seq_index,
    input  logic [11:0] i_offset,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [5:0]  o_given_index,
    output logic [11:0] o_address
);
    import bfsra_pkg::*;

    typedef enum logic [2:0] {
        S_FILL, S_IDLE, S_SCAN, S_ALLOC, S_SHUP, S_SHDN, S_INS, S_RESP
    } t_state;

    t_state r_state;

    // control
    logic [CNT_W-1:0]  r_count;
    logic [63:0]       r_map;
    logic [CNT_W-1:0]  r_ptr;
    logic [CNT_W-1:0]  r_pidx;
    logic              r_dv;
    logic              r_wv;
    logic              r_more;
    logic [SEG_AW-1:0] r_waddr;
    logic              r_have;
    logic              r_out_valid;

    // payload
    logic [1:0]        r_mode;
    logic [12:0]       r_len;
    logic [5:0]        r_idx;
    logic [11:0]       r_off;
    logic [13:0]       r_addr;
    logic [11:0]       r_best_addr;
    logic [12:0]       r_fit_size;
    logic [SEG_AW-1:0] r_pos;
    logic [11:0]       r_start;
    logic [5:0]        r_new_idx;
    logic [2:0]        r_res_status;
    logic [5:0]        r_res_idx;
    logic [11:0]       r_res_addr;
    logic [2:0]        r_o_status;
    logic [5:0]        r_o_idx;
    logic [11:0]       r_o_addr;

    // table ram
    logic              mem_we;
    logic [SEG_AW-1:0] mem_waddr;
    t_seg              mem_wdata;
    logic [SEG_AW-1:0] mem_raddr;
    t_seg              rd;
    logic [$bits(t_seg)-1:0] rd_bits;

    bfsra_ram #(
        .WIDTH ($bits(t_seg)),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_bits)
    );

    assign rd = t_seg'(rd_bits);

    // gap in front of the entry being examined
    logic [12:0] gap;
    logic        last;
    logic [5:0]  free_idx;
    logic [SEG_AW-1:0] pidx_a;

    assign pidx_a = r_pidx[SEG_AW-1:0];
    assign gap  = ({2'b00, rd.start} >= r_addr) ? {1'b0, rd.start - r_addr[11:0]} : 13'd0;
    assign last = (r_pidx == r_count - CNT_W'(1));

    // lowest free index
    always_comb begin
        free_idx = 6'd0;
        for (int i = 63; i >= 0; i--) begin
            if (!r_map[i]) begin
                free_idx = 6'(i);
            end
        end
    end

    // ram port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_waddr;
        mem_wdata = rd;
        mem_raddr = r_ptr[SEG_AW-1:0];
        unique case (r_state)
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr[SEG_AW-1:0];
                if (r_ptr == '0) begin
                    mem_wdata = '{start: 12'd0, size: 13'd1, owner: 6'd0};
                end else begin
                    mem_wdata = '{start: ADDR_MASK, size: 13'd1, owner: 6'd1};
                end
            end
            S_SHUP, S_SHDN: begin
                mem_we = r_wv;
            end
            S_INS: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = '{start: r_best_addr, size: r_len, owner: r_new_idx};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_given_index = r_o_idx;
    assign o_address     = r_o_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_count     <= CNT_W'(2);
            r_map       <= 64'd3;
            r_ptr       <= '0;
            r_pidx      <= '0;
            r_dv        <= 1'b0;
            r_wv        <= 1'b0;
            r_more      <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_FILL: begin
                    // write both trap segments
                    r_ptr <= r_ptr + CNT_W'(1);
                    if (r_ptr != '0) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode       <= i_mode;
                        r_len        <= i_length;
                        r_idx        <= i_seq_index;
                        r_off        <= i_offset;
                        r_ptr        <= '0;
                        r_dv         <= 1'b0;
                        r_have       <= 1'b0;
                        r_addr       <= '0;
                        r_best_addr  <= '0;
                        r_fit_size   <= '0;
                        r_res_status <= ST_OK;
                        r_res_idx    <= '0;
                        r_res_addr   <= '0;
                        r_state      <= S_SCAN;
                        unique case (i_mode)
                            MODE_ALLOC: begin
                                if (i_length == '0 || r_count == '0) begin
                                    r_res_status <= ST_NO_SPACE;
                                    r_state      <= S_RESP;
                                end
                            end
                            MODE_FREE: begin
                                if (!r_map[i_seq_index]) begin
                                    r_res_status <= ST_UNUSED;
                                    r_state      <= S_RESP;
                                end else begin
                                    r_map[i_seq_index] <= 1'b0;
                                    if (r_count == '0) begin
                                        r_res_status <= ST_NOT_FOUND;
                                        r_state      <= S_RESP;
                                    end
                                end
                            end
                            MODE_LOOKUP: begin
                                if (r_count == '0) begin
                                    r_res_status <= ST_NOT_FOUND;
                                    r_state      <= S_RESP;
                                end
                            end
                            default: begin
                                r_res_status <= ST_NOT_FOUND;
                                r_state      <= S_RESP;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // issue reads in order, evaluate each in the cycle after its read
                    if (r_ptr < r_count) begin
                        r_pidx <= r_ptr;
                        r_dv   <= 1'b1;
                        r_ptr  <= r_ptr + CNT_W'(1);
                    end else begin
                        r_dv <= 1'b0;
                    end
                    if (r_dv) begin
                        if (r_mode == MODE_ALLOC) begin
                            r_addr <= 14'(rd.start) + 14'(rd.size);
                            if (gap == r_len) begin
                                r_have      <= 1'b1;
                                r_best_addr <= r_addr[11:0];
                                r_fit_size  <= gap;
                                r_pos       <= pidx_a;
                                r_state     <= S_ALLOC;
                            end else begin
                                if (gap > r_len && (!r_have || gap < r_fit_size)) begin
                                    r_have      <= 1'b1;
                                    r_best_addr <= r_addr[11:0];
                                    r_fit_size  <= gap;
                                    r_pos       <= pidx_a;
                                end
                                if (last) begin
                                    r_state <= S_ALLOC;
                                end
                            end
                        end else if (rd.owner == r_idx) begin
                            if (r_mode == MODE_LOOKUP) begin
                                r_res_addr <= (rd.start + r_off) & ADDR_MASK;
                                r_state    <= S_RESP;
                            end else begin
                                r_start <= rd.start;
                                r_ptr   <= r_pidx + CNT_W'(1);
                                r_wv    <= 1'b0;
                                r_state <= S_SHDN;
                            end
                        end else if (last) begin
                            r_res_status <= ST_NOT_FOUND;
                            r_state      <= S_RESP;
                        end
                    end
                end
                S_ALLOC: begin
                    if (!r_have) begin
                        r_res_status <= ST_NO_SPACE;
                        r_state      <= S_RESP;
                    end else if (&r_map || r_count >= CNT_W'(MAX_SEGMENTS)) begin
                        r_res_status <= ST_EXHAUSTED;
                        r_state      <= S_RESP;
                    end else begin
                        r_new_idx <= free_idx;
                        r_ptr     <= r_count - CNT_W'(1);
                        r_more    <= 1'b1;
                        r_wv      <= 1'b0;
                        r_state   <= S_SHUP;
                    end
                end
                S_SHUP: begin
                    // move entries pos..count-1 up by one, top first
                    if (r_more) begin
                        r_waddr <= SEG_AW'(r_ptr + CNT_W'(1));
                        r_wv    <= 1'b1;
                        r_more  <= (r_ptr[SEG_AW-1:0] != r_pos);
                        r_ptr   <= r_ptr - CNT_W'(1);
                    end else begin
                        r_wv <= 1'b0;
                        if (!r_wv) begin
                            r_state <= S_INS;
                        end
                    end
                end
                S_INS: begin
                    r_map[r_new_idx] <= 1'b1;
                    r_count          <= r_count + CNT_W'(1);
                    r_res_idx        <= r_new_idx;
                    r_res_addr       <= r_best_addr;
                    r_state          <= S_RESP;
                end
                S_SHDN: begin
                    // move entries above pos down by one, bottom first
                    if (r_ptr < r_count) begin
                        r_waddr <= SEG_AW'(r_ptr - CNT_W'(1));
                        r_wv    <= 1'b1;
                        r_ptr   <= r_ptr + CNT_W'(1);
                    end else begin
                        r_wv <= 1'b0;
                        if (!r_wv) begin
                            r_count    <= r_count - CNT_W'(1);
                            r_res_addr <= r_start;
                            r_state    <= S_RESP;
                        end
                    end
                end
                S_RESP: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= r_res_status;
                        r_o_idx     <= r_res_idx;
                        r_o_addr    <= r_res_addr;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hdl/bfsra_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsra_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bfsra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/bfsra_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsra_checker
// port-level checks on the allocator result channel
// ----------------------------------------------------------------------------
module bfsra_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_status,
    input logic [5:0]  o_given_index,
    input logic [11:0] o_address
);
    import bfsra_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_address)
            && $stable(o_status) && $stable(o_given_index))
        else $error("result word changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= ST_NOT_FOUND)
        else $error("status code out of range");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_address == '0 && o_given_index == '0)
        else $error("failed word carries data");

endmodule

bind best_fit_sequence_ram_allocator_core bfsra_checker u_bfsra_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_given_index (o_given_index),
    .o_address     (o_address)
);

>>> sim/bfsra_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsra_scoreboard
// watches both channels, predicts each result word and compares it
// ----------------------------------------------------------------------------
module bfsra_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [12:0] i_length,
    input  logic [5:0]  i_seq_index,
    input  logic [11:0] i_offset,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_status,
    input  logic [5:0]  i_given_index,
    input  logic [11:0] i_address,
    output int          o_pending,
    output int          o_fail_count
);
    import bfsra_pkg::*;

    typedef struct {
        logic [2:0]  status;
        logic [5:0]  given_index;
        logic [11:0] address;
    } t_alloc_result;

    // model of the segment table, in address order
    logic [11:0] seg_start [MAX_SEGMENTS];
    logic [12:0] seg_len   [MAX_SEGMENTS];
    logic [5:0]  seg_owner [MAX_SEGMENTS];
    int          seg_count;
    logic [63:0] used_map;

    t_alloc_result awaited_results[$];

    function automatic void clear_table();
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            seg_start[i] = '0;
            seg_len[i]   = '0;
            seg_owner[i] = '0;
        end
        seg_len[0]   = 13'd1;
        seg_start[1] = ADDR_MASK;
        seg_len[1]   = 13'd1;
        seg_owner[1] = 6'd1;
        seg_count    = 2;
        used_map     = 64'd3;
    endfunction

    function automatic int owner_pos(logic [5:0] idx);
        for (int i = 0; i < seg_count; i++)
            if (seg_owner[i] == idx) return i;
        return -1;
    endfunction

    function automatic t_alloc_result allocate_segment(logic [12:0] len);
        t_alloc_result r;
        int addr, best_addr, fit_size, best_pos, gap, s, idx;
        bit have;
        r = '{ST_NO_SPACE, 6'd0, 12'd0};
        addr = 0; best_addr = 0; fit_size = 0; best_pos = 0; have = 0; idx = 0;
        if (len == 0) return r;
        // only gaps in front of a segment count
        for (int i = 0; i < seg_count; i++) begin
            s = seg_start[i];
            gap = (s >= addr) ? s - addr : 0;
            if (gap == len) begin
                best_addr = addr; fit_size = gap; best_pos = i; have = 1;
                break;
            end
            if (gap > len && (!have || gap < fit_size)) begin
                best_addr = addr; fit_size = gap; best_pos = i; have = 1;
            end
            addr = s + seg_len[i];
        end
        if (!have) return r;
        if (used_map == '1 || seg_count >= MAX_SEGMENTS) begin
            r.status = ST_EXHAUSTED;
            return r;
        end
        for (int i = 0; i < 64; i++)
            if (!used_map[i]) begin
                idx = i;
                break;
            end
        used_map[idx] = 1'b1;
        for (int i = seg_count; i > best_pos; i--) begin
            seg_start[i] = seg_start[i-1];
            seg_len[i]   = seg_len[i-1];
            seg_owner[i] = seg_owner[i-1];
        end
        seg_start[best_pos] = best_addr[11:0];
        seg_len[best_pos]   = len;
        seg_owner[best_pos] = idx[5:0];
        seg_count++;
        r = '{ST_OK, idx[5:0], best_addr[11:0]};
        return r;
    endfunction

    function automatic t_alloc_result free_segment(logic [5:0] idx);
        t_alloc_result r;
        int pos;
        r = '{ST_UNUSED, 6'd0, 12'd0};
        if (!used_map[idx]) return r;
        used_map[idx] = 1'b0;
        pos = owner_pos(idx);
        if (pos < 0) begin
            r.status = ST_NOT_FOUND;
            return r;
        end
        r = '{ST_OK, 6'd0, seg_start[pos]};
        for (int i = pos; i + 1 < seg_count; i++) begin
            seg_start[i] = seg_start[i+1];
            seg_len[i]   = seg_len[i+1];
            seg_owner[i] = seg_owner[i+1];
        end
        seg_count--;
        seg_start[seg_count] = '0;
        seg_len[seg_count]   = '0;
        seg_owner[seg_count] = '0;
        return r;
    endfunction

    function automatic t_alloc_result predict_word(logic [1:0] mode, logic [12:0] len,
                                                   logic [5:0] idx, logic [11:0] off);
        t_alloc_result r;
        int pos;
        r = '{ST_NOT_FOUND, 6'd0, 12'd0};
        case (mode)
            MODE_ALLOC: r = allocate_segment(len);
            MODE_FREE:  r = free_segment(idx);
            MODE_LOOKUP: begin
                pos = owner_pos(idx);
                if (pos >= 0) r = '{ST_OK, 6'd0, (seg_start[pos] + off) & ADDR_MASK};
            end
            default: ;
        endcase
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        clear_table();
    end

    always @(posedge i_clk) begin
        t_alloc_result want;
        if (!i_rst_n) begin
            clear_table();
            awaited_results.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                awaited_results.insert(awaited_results.size(),
                                       predict_word(i_mode, i_length, i_seq_index,
                                                    i_offset));
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result word with nothing awaited");
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        o_fail_count++;
                    end
                    if (i_given_index !== want.given_index) begin
                        $error("given_index: expected %0d, got %0d", want.given_index,
                               i_given_index);
                        o_fail_count++;
                    end
                    if (i_address !== want.address) begin
                        $error("address: expected %0d, got %0d", want.address, i_address);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

>>> sim/tb_best_fit_sequence_ram_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_fit_sequence_ram_allocator_core
// directed and random allocate, free and lookup words under idle and stall
// ----------------------------------------------------------------------------
module tb_best_fit_sequence_ram_allocator_core;
    import bfsra_pkg::*;

    // mode with no operation behind it, answered with not found
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int WORDS_PER_PHASE = 320;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_mode;
    logic [12:0] i_length;
    logic [5:0]  i_seq_index;
    logic [11:0] i_offset;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_status;
    logic [5:0]  o_given_index;
    logic [11:0] o_address;

    int pending;
    int fail_count;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;

    best_fit_sequence_ram_allocator_core DUT (.*);

    bfsra_scoreboard u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_length     (i_length),
        .i_seq_index  (i_seq_index),
        .i_offset     (i_offset),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_status     (o_status),
        .i_given_index(o_given_index),
        .i_address    (o_address),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: the run must finish well inside the cycle limit
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off whenever one is requested
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                i_out_ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // offer one word, idling first at the sender's rate; returns on the accepting edge
    task automatic send_word(logic [1:0] mode, logic [12:0] len, logic [5:0] idx,
                             logic [11:0] off);
        bit rdy;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= mode;
        i_length    <= len;
        i_seq_index <= idx;
        i_offset    <= off;
        do begin
            // ready is stable mid-cycle, so sample it at the falling edge
            @(negedge i_clk);
            rdy = o_in_ready;
            @(posedge i_clk);
        end while (!rdy);
    endtask

    task automatic drop_valid();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly short lengths so the table fills; now and then any length from 0 to 4096
    function automatic logic [12:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 80) return 13'($urandom_range(32, 1));
        if (r < 95) return 13'($urandom_range(600, 33));
        return 13'($urandom_range(4096, 0));
    endfunction

    // alternate fill-heavy and drain-heavy stretches so exhaustion is reached
    task automatic random_words(int count);
        int r;
        bit filling;
        logic [1:0] mode;
        for (int n = 0; n < count; n++) begin
            filling = ((n / 80) % 2) == 0;
            r = $urandom_range(99);
            if (r < 4)
                mode = MODE_SPARE;
            else if (r < (filling ? 75 : 25))
                mode = MODE_ALLOC;
            else if (r < (filling ? 87 : 75))
                mode = MODE_FREE;
            else
                mode = MODE_LOOKUP;
            send_word(mode, pick_length(), 6'($urandom_range(63)),
                      12'($urandom_range(4095)));
        end
    endtask

    task automatic directed_words();
        send_word(MODE_ALLOC,  13'd0,    6'd0,  12'd0);     // zero length
        send_word(MODE_ALLOC,  13'd4096, 6'd63, 12'hfff);   // bigger than the ram
        send_word(MODE_ALLOC,  13'd2047, 6'd0,  12'd0);     // just too big
        send_word(MODE_ALLOC,  13'd2046, 6'd0,  12'd0);     // exact fit of the free gap
        send_word(MODE_LOOKUP, 13'd0,    6'd2,  12'hfff);   // offset wraps
        send_word(MODE_ALLOC,  13'd1,    6'd0,  12'd0);     // no gap left
        send_word(MODE_FREE,   13'd0,    6'd2,  12'd0);
        send_word(MODE_FREE,   13'd0,    6'd2,  12'd0);     // already unused
        send_word(MODE_LOOKUP, 13'd0,    6'd2,  12'd5);     // no segment
        send_word(MODE_ALLOC,  13'd100,  6'd0,  12'd0);
        send_word(MODE_ALLOC,  13'd10,   6'd0,  12'd0);
        send_word(MODE_FREE,   13'd0,    6'd2,  12'd0);     // leaves a 100-word hole
        send_word(MODE_ALLOC,  13'd50,   6'd0,  12'd0);     // best fit takes the hole
        send_word(MODE_LOOKUP, 13'd0,    6'd3,  12'd0);
        send_word(MODE_LOOKUP, 13'd0,    6'd0,  12'd0);     // trap at address 0
        send_word(MODE_LOOKUP, 13'd0,    6'd1,  12'd1);     // top trap, wraps to 0
        send_word(MODE_SPARE,  13'h1fff, 6'h3f, 12'hfff);   // unused mode, all ones
        send_word(MODE_FREE,   13'd0,    6'd63, 12'd0);
        send_word(MODE_FREE,   13'd0,    6'd0,  12'd0);     // drop the low trap
        send_word(MODE_ALLOC,  13'd3,    6'd0,  12'd0);     // best fit, the 50-word gap at address 51
        send_word(MODE_LOOKUP, 13'd0,    6'd0,  12'd7);
        send_word(MODE_FREE,   13'd0,    6'd1,  12'd0);     // drop the top trap
        send_word(MODE_ALLOC,  13'd4,    6'd0,  12'd0);
        drop_valid();
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (pending != 0);
        repeat (200) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_mode = MODE_ALLOC;
        i_length = '0;
        i_seq_index = '0;
        i_offset = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full rate on both sides
        directed_words();
        random_words(WORDS_PER_PHASE);
        drop_valid();

        // slow sender; long receiver hold-off first to back up the input
        send_idle_pct = 86;
        recv_stall_pct = 0;
        hold_off_cycles = 2000;
        send_idle_pct = 0;
        random_words(20);
        send_idle_pct = 86;
        random_words(WORDS_PER_PHASE);
        drop_valid();

        // stalling receiver
        send_idle_pct = 0;
        recv_stall_pct = 86;
        random_words(WORDS_PER_PHASE);
        drop_valid();

        // both sides gappy
        send_idle_pct = 38;
        recv_stall_pct = 38;
        random_words(WORDS_PER_PHASE);
        drop_valid();

        recv_stall_pct = 0;
        wait_drained();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
